>>> rtl/core/c3x3_pkg.sv
// ----------------------------------------------------------------------------
// c3x3_pkg: shared definitions of the 3x3 grayscale convolution
// Field widths, coefficient format, register indexes and RAM word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package c3x3_pkg;

  localparam int PIX_W         = 8;
  localparam int COEF_W        = 16;
  localparam int COEF_FRAC_BITS = 8;
  localparam int KROW_W        = 3 * COEF_W;
  localparam int CFG_WIDTH_W   = 11;
  localparam int CFG_HEIGHT_W  = 16;
  localparam int CFG_DATA_W    = KROW_W;
  localparam int CFG_IDX_W     = 3;
  localparam int RES_ROW_W     = 16;
  localparam int RES_COL_W     = 10;
  // The row counter runs up to two past the last image row while the frame drains.
  localparam int ROW_CNT_W     = CFG_HEIGHT_W + 1;
  localparam int PROD_W        = PIX_W + 1 + COEF_W;
  localparam int SUM_W         = PROD_W + 4;
  localparam int LINE_W        = 2 * PIX_W;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = CFG_WIDTH_W'(1024);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = CFG_HEIGHT_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

`default_nettype wire

>>> rtl/core/c3x3_if.sv
// ----------------------------------------------------------------------------
// c3x3_if: stream channels of the 3x3 convolution
// Pixel request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface c3x3_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [c3x3_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output operation, output pixel, input ready);
  modport sink   (input valid, input operation, input pixel, output ready);
endinterface

interface c3x3_out_if;
  logic                          valid;
  logic                          ready;
  logic [c3x3_pkg::PIX_W-1:0]     result_pixel;
  logic [c3x3_pkg::RES_ROW_W-1:0] result_row;
  logic [c3x3_pkg::RES_COL_W-1:0] result_col;
  logic                          end_of_frame;

  modport source (output valid, output result_pixel, output result_row,
                  output result_col, output end_of_frame, input ready);
  modport sink   (input valid, input result_pixel, input result_row,
                  input result_col, input end_of_frame, output ready);
endinterface

`default_nettype wire

>>> rtl/core/conv3x3_gray_zero_pad.sv
// ----------------------------------------------------------------------------
// conv3x3_gray_zero_pad: streaming 3x3 grayscale convolution, zero padding
// Line buffers in RAM, 3x3 window, nine parallel multipliers, round, clamp.
// ----------------------------------------------------------------------------
// Pixels enter on in_ch in raster order, one request per pixel; a request
// with operation set is a drain request that carries a zero sample. Each
// request yields zero or one result on out_ch with its row, column and an
// end_of_frame flag on the last result. A frame of H rows by W pixels needs
// W+1 drain requests after its last pixel to flush all results.
// Throughput is one request per clock while out_ch does not stall. A request
// reaches its result through the line buffer RAM read and the product
// register, then sum, round and clamp into the output register.
// The line buffer RAM has one read and one write port; a write that lands on
// the address being read in the same cycle is forwarded.
// The kernel, width and height are written over the cfg port while idle.
// After reset the kernel is zero, width and height are 1024, the window is
// cleared and the position is row 0, column 0; the RAM needs no clearing.
// When out_ch stalls, results stay in the output register and the pipeline
// fills its empty stages before in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_gray_zero_pad #(
  parameter int MAX_WIDTH = c3x3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  c3x3_in_if.sink                                in_ch,
  c3x3_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [c3x3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [c3x3_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > c3x3_pkg::CFG_WIDTH_W) ? CW : c3x3_pkg::CFG_WIDTH_W;
  localparam int RB = c3x3_pkg::ROW_CNT_W;
  localparam int RoundHalf = 1 << (c3x3_pkg::COEF_FRAC_BITS - 1);

  typedef struct packed {
    c3x3_pkg::pix_t                 sample;
    logic [CB-1:0]                  addr;
    logic                           emit;
    logic                           eof;
    logic [c3x3_pkg::RES_ROW_W-1:0] row;
    logic [c3x3_pkg::RES_COL_W-1:0] col;
    logic [2:0]                     rmask;
    logic [2:0]                     cmask;
  } s1_t;

  // Configuration registers
  logic [c3x3_pkg::KROW_W-1:0]       kern_r [3];
  logic [c3x3_pkg::CFG_WIDTH_W-1:0]  width_r;
  logic [c3x3_pkg::CFG_HEIGHT_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_r[0] <= '0;
      kern_r[1] <= '0;
      kern_r[2] <= '0;
      width_r   <= c3x3_pkg::WIDTH_RST;
      height_r  <= c3x3_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        c3x3_pkg::REG_KERNEL_TOP:    kern_r[0] <= cfg_data;
        c3x3_pkg::REG_KERNEL_MID:    kern_r[1] <= cfg_data;
        c3x3_pkg::REG_KERNEL_BOTTOM: kern_r[2] <= cfg_data;
        c3x3_pkg::REG_IMAGE_WIDTH:   width_r <= cfg_data[c3x3_pkg::CFG_WIDTH_W-1:0];
        c3x3_pkg::REG_IMAGE_HEIGHT:  height_r <= cfg_data[c3x3_pkg::CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size
  logic [WW-1:0] w_ext;
  logic [WW-1:0] w_eff;
  logic [RB-1:0] h_eff;

  always_comb begin
    w_ext = WW'(width_r);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (height_r == '0) ? RB'(1) : RB'(height_r);
  end

  // Handshake control
  logic s1_v_r, s2_v_r, out_v_r;
  s1_t  s1_r;
  logic s1_go, s2_go, s2_free, accept;

  assign s2_go   = s2_v_r && (!out_v_r || out_ch.ready);
  assign s2_free = !s2_v_r || s2_go;
  assign s1_go   = s1_v_r && (!s1_r.emit || s2_free);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign accept  = in_ch.valid && in_ch.ready;

  // Input position and result bookkeeping
  logic [CB-1:0] in_col_r, in_col_nxt;
  logic [RB-1:0] in_row_r, in_row_nxt;
  logic [CB-1:0] c0;
  logic [RB-1:0] r0;
  logic [RB-1:0] orow;
  logic [WW-1:0] ocol;
  logic [WW-1:0] c1;
  logic          emit, eof;
  s1_t           s1_nxt;

  always_comb begin
    if (WW'(in_col_r) >= w_eff) begin
      c0 = '0;
      r0 = in_row_r + RB'(1);
    end else begin
      c0 = in_col_r;
      r0 = in_row_r;
    end

    if (c0 == '0) begin
      emit = (r0 >= RB'(2));
      orow = r0 - RB'(2);
      ocol = w_eff - WW'(1);
      eof  = emit && (r0 >= h_eff + RB'(1));
    end else begin
      emit = (r0 >= RB'(1)) && (r0 <= h_eff);
      orow = r0 - RB'(1);
      ocol = WW'(c0) - WW'(1);
      eof  = 1'b0;
    end

    c1 = WW'(c0) + WW'(1);
    if (eof) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if (c1 >= w_eff) begin
      in_col_nxt = '0;
      in_row_nxt = r0 + RB'(1);
    end else begin
      in_col_nxt = CB'(c1);
      in_row_nxt = r0;
    end

    s1_nxt.sample = (in_ch.operation == c3x3_pkg::OP_PIXEL && r0 < h_eff)
                    ? in_ch.pixel : '0;
    s1_nxt.addr   = c0;
    s1_nxt.emit   = emit;
    s1_nxt.eof    = eof;
    s1_nxt.row    = c3x3_pkg::RES_ROW_W'(orow);
    s1_nxt.col    = c3x3_pkg::RES_COL_W'(ocol);
    // Neighbor rows and columns that fall outside the image are masked.
    s1_nxt.rmask[0] = (orow >= RB'(1)) && (orow <= h_eff);
    s1_nxt.rmask[1] = (orow < h_eff);
    s1_nxt.rmask[2] = ((orow + RB'(1)) < h_eff);
    s1_nxt.cmask[0] = (ocol >= WW'(1));
    s1_nxt.cmask[1] = (ocol < w_eff);
    s1_nxt.cmask[2] = ((ocol + WW'(1)) < w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
    end else if (accept) begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
    end
  end

  // Line buffer RAM: upper line in the high byte, lower line in the low byte
  logic                           ram_we;
  logic [c3x3_pkg::LINE_W-1:0]    ram_wdata;
  logic [c3x3_pkg::LINE_W-1:0]    ram_rdata;
  logic                           byp_r;
  logic [c3x3_pkg::LINE_W-1:0]    byp_data_r;
  logic [c3x3_pkg::LINE_W-1:0]    line_rd;

  assign ram_we    = s1_go;
  assign line_rd   = byp_r ? byp_data_r : ram_rdata;
  assign ram_wdata = {line_rd[c3x3_pkg::PIX_W-1:0], s1_r.sample};

  c3x3_ram #(
    .WIDTH (c3x3_pkg::LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_r.addr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (c0),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
    if (accept) begin
      s1_r <= s1_nxt;
      // The RAM returns old data when it is written at the address being read.
      byp_r      <= ram_we && (s1_r.addr == c0);
      byp_data_r <= ram_wdata;
    end
  end

  // Window shift and products
  c3x3_pkg::pix_t win_r   [3][3];
  c3x3_pkg::pix_t win_nxt [3][3];
  c3x3_pkg::prod_t prod_nxt [9];
  c3x3_pkg::prod_t prod_r   [9];
  logic signed [c3x3_pkg::COEF_W-1:0] coef;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = line_rd[c3x3_pkg::LINE_W-1:c3x3_pkg::PIX_W];
    win_nxt[1][2] = line_rd[c3x3_pkg::PIX_W-1:0];
    win_nxt[2][2] = s1_r.sample;

    coef = '0;
    for (int k = 0; k < 3; k++) begin
      for (int l = 0; l < 3; l++) begin
        // True convolution: the kernel is flipped in both axes.
        coef = kern_r[2-k][c3x3_pkg::COEF_W*(2-l) +: c3x3_pkg::COEF_W];
        if (s1_r.rmask[k] && s1_r.cmask[l]) begin
          prod_nxt[3*k+l] = $signed({1'b0, win_nxt[k][l]}) * coef;
        end else begin
          prod_nxt[3*k+l] = '0;
        end
      end
    end
  end

  logic [c3x3_pkg::RES_ROW_W-1:0] s2_row_r;
  logic [c3x3_pkg::RES_COL_W-1:0] s2_col_r;
  logic                           s2_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          win_r[k][l] <= '0;
        end
      end
    end else if (s1_go) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_go && s1_r.emit;
    end
    if (s2_free && s1_go && s1_r.emit) begin
      prod_r   <= prod_nxt;
      s2_row_r <= s1_r.row;
      s2_col_r <= s1_r.col;
      s2_eof_r <= s1_r.eof;
    end
  end

  // Sum, round to nearest (halves up), clamp to the pixel range
  logic signed [c3x3_pkg::SUM_W-1:0] sum;
  logic signed [c3x3_pkg::SUM_W-1:0] rnd;
  logic signed [c3x3_pkg::SUM_W-1:0] shifted;
  c3x3_pkg::pix_t                    res_pix;

  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      sum = sum + c3x3_pkg::SUM_W'(prod_r[i]);
    end
    rnd     = sum + c3x3_pkg::SUM_W'(RoundHalf);
    shifted = rnd >>> c3x3_pkg::COEF_FRAC_BITS;
    if (rnd < 0) begin
      res_pix = '0;
    end else if (shifted > c3x3_pkg::SUM_W'(255)) begin
      res_pix = '1;
    end else begin
      res_pix = shifted[c3x3_pkg::PIX_W-1:0];
    end
  end

  logic [c3x3_pkg::PIX_W-1:0]     out_pix_r;
  logic [c3x3_pkg::RES_ROW_W-1:0] out_row_r;
  logic [c3x3_pkg::RES_COL_W-1:0] out_col_r;
  logic                           out_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= s2_v_r;
    end
    if (s2_go) begin
      out_pix_r <= res_pix;
      out_row_r <= s2_row_r;
      out_col_r <= s2_col_r;
      out_eof_r <= s2_eof_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_pixel = out_pix_r;
  assign out_ch.result_row   = out_row_r;
  assign out_ch.result_col   = out_col_r;
  assign out_ch.end_of_frame = out_eof_r;

  // Checks
  a_emit_reaches_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_r.emit) |=> s2_v_r)
    else $error("emitting item lost between window and product stages");

  a_s2_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go |=> out_v_r)
    else $error("product stage result lost before output register");

  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eof) |=> (in_row_r == '0 && in_col_r == '0))
    else $error("position did not return to the frame start after end of frame");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && s1_r.emit && s2_v_r && out_v_r))
    else $error("input stalled while the pipeline had room");

endmodule

`default_nettype wire

>>> rtl/core/c3x3_ram.sv
// ----------------------------------------------------------------------------
// c3x3_ram: simple dual-port RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module c3x3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
